/* hdl/onrt_pkg.sv */
// Package for the ordered node reference table: item types, codes and control structs.
`timescale 1ns / 1ps
`default_nettype none
package onrt_pkg;

    // Default table geometry
    localparam int DEPTH       = 1024;
    localparam int OFFSET_BITS = 32;

    // Fixed field widths of the item ports
    localparam int REF_W     = 12;
    localparam int OFF_IN_W  = 32;
    localparam int OFF_OUT_W = 32;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_MARK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADREF = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        t_cmd                    command;
        logic [OFF_IN_W-1:0]     node_offset;
        logic                    sent_on_insert;
        logic signed [REF_W-1:0] ref_number;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [REF_W-1:0] result_ref;
        logic [OFF_OUT_W-1:0]    offset_out;
        t_status                 status;
    } t_out;

    // Address counter operation
    typedef enum logic [1:0] {
        ADDR_HOLD = 2'd0,
        ADDR_ZERO = 2'd1,
        ADDR_MAG  = 2'd2
    } t_addr_op;

    // Result register source
    typedef enum logic [2:0] {
        RES_HOLD = 3'd0,
        RES_OK   = 3'd1,
        RES_FULL = 3'd2,
        RES_BAD  = 3'd3,
        RES_INS  = 3'd4,
        RES_HIT  = 3'd5,
        RES_RD   = 3'd6
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     wr_insert;
        logic     wr_mark;
        t_addr_op addr_op;
        logic     scan;
        t_res_sel res_sel;
        logic     push;
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic mag_zero;
        logic mag_bad;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* hdl/onrt_datapath.sv */
// Datapath of the ordered node reference table: item capture, entry memories, scan and results.
`timescale 1ns / 1ps
`default_nettype none
module onrt_datapath #(
    parameter int DEPTH       = onrt_pkg::DEPTH,
    parameter int OFFSET_BITS = onrt_pkg::OFFSET_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire onrt_pkg::t_in  i_in_item,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output onrt_pkg::t_out      o_out_item,
    input  wire onrt_pkg::t_ctrl i_ctrl,
    output onrt_pkg::t_stat     o_stat
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > onrt_pkg::REF_W) ? CNT_W : onrt_pkg::REF_W;
    localparam int REF_W  = onrt_pkg::REF_W;

    onrt_pkg::t_in          r_item;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W-1:0]      n_addr;
    logic [ADDR_W-1:0]      r_rd_idx;
    logic                   r_rd_vld;
    logic [OFFSET_BITS-1:0] r_rd_off;
    logic                   r_rd_flag;
    onrt_pkg::t_out         r_res;
    onrt_pkg::t_out         n_res;
    onrt_pkg::t_out         r_out;
    logic                   r_out_vld;

    logic [OFFSET_BITS-1:0] mem_off  [DEPTH];
    logic                   mem_flag [DEPTH];

    logic [OFFSET_BITS-1:0]         w_key;
    logic [onrt_pkg::OFF_OUT_W-1:0] w_rd_out;
    logic [REF_W-1:0]               w_raw;
    logic [REF_W-1:0]               w_mag;
    logic [CMP_W-1:0]               w_mag_ext;
    logic [CMP_W-1:0]               w_mag_m1;
    logic [CMP_W-1:0]               w_hit_ref;
    logic [CMP_W-1:0]               w_ins_ref;
    logic [ADDR_W-1:0]              w_ins_addr;
    logic                           w_addr_end;
    logic                           w_out_free;

    // Fit the offset to the stored width
    for (genvar gi = 0; gi < OFFSET_BITS; gi++) begin : g_key
        if (gi < onrt_pkg::OFF_IN_W) begin : g_bit
            assign w_key[gi] = r_item.node_offset[gi];
        end else begin : g_pad
            assign w_key[gi] = 1'b0;
        end
    end

    // Fit the stored offset to the result field
    for (genvar go = 0; go < onrt_pkg::OFF_OUT_W; go++) begin : g_rd
        if (go < OFFSET_BITS) begin : g_bit
            assign w_rd_out[go] = r_rd_off[go];
        end else begin : g_pad
            assign w_rd_out[go] = 1'b0;
        end
    end

    // Take the magnitude of the reference
    assign w_raw      = r_item.ref_number;
    assign w_mag      = w_raw[REF_W-1] ? (REF_W'(0) - w_raw) : w_raw;
    assign w_mag_ext  = CMP_W'(w_mag);
    assign w_mag_m1   = w_mag_ext - CMP_W'(1);
    assign w_hit_ref  = CMP_W'(r_rd_idx) + CMP_W'(1);
    assign w_ins_ref  = CMP_W'(r_count) + CMP_W'(1);
    assign w_ins_addr = r_count[ADDR_W-1:0];
    assign w_addr_end = (CNT_W'(r_addr) + CNT_W'(1)) == r_count;
    assign w_out_free = !r_out_vld || !i_out_stall;

    // Report status to the controller
    always_comb begin
        o_stat.cmd      = r_item.command;
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CNT_W'(DEPTH));
        o_stat.mag_zero = (w_mag == '0);
        o_stat.mag_bad  = (w_mag_ext > CMP_W'(r_count));
        o_stat.hit      = r_rd_vld && (r_rd_off == w_key);
        o_stat.last     = r_rd_vld && ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);
        o_stat.out_free = w_out_free;
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_item <= i_in_item;
        end
    end

    // Count stored entries
    always_comb begin
        n_count = r_count;
        if (i_ctrl.wr_insert) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Step the memory address
    always_comb begin
        n_addr = r_addr;
        unique case (i_ctrl.addr_op)
            onrt_pkg::ADDR_ZERO: n_addr = '0;
            onrt_pkg::ADDR_MAG:  n_addr = w_mag_m1[ADDR_W-1:0];
            default: begin
                if (i_ctrl.scan && !w_addr_end) begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_ctrl.scan;
        end
        r_addr   <= n_addr;
        r_rd_idx <= r_addr;
    end

    // Write and read the entry memories
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_insert) begin
            mem_off[w_ins_addr]  <= w_key;
            mem_flag[w_ins_addr] <= r_item.sent_on_insert;
        end else if (i_ctrl.wr_mark) begin
            mem_flag[w_mag_m1[ADDR_W-1:0]] <= 1'b1;
        end
        r_rd_off  <= mem_off[r_addr];
        r_rd_flag <= mem_flag[r_addr];
    end

    // Build the result
    always_comb begin
        n_res = r_res;
        unique case (i_ctrl.res_sel)
            onrt_pkg::RES_HOLD: n_res = r_res;
            onrt_pkg::RES_OK: begin
                n_res = '{result_ref: '0, offset_out: '0, status: onrt_pkg::ST_OK};
            end
            onrt_pkg::RES_FULL: begin
                n_res = '{result_ref: '0, offset_out: '0, status: onrt_pkg::ST_FULL};
            end
            onrt_pkg::RES_BAD: begin
                n_res = '{result_ref: '0, offset_out: '0, status: onrt_pkg::ST_BADREF};
            end
            onrt_pkg::RES_INS: begin
                n_res = '{result_ref: w_ins_ref[REF_W-1:0], offset_out: '0,
                          status: onrt_pkg::ST_OK};
            end
            onrt_pkg::RES_HIT: begin
                n_res.result_ref = r_rd_flag ? w_hit_ref[REF_W-1:0]
                                             : (REF_W'(0) - w_hit_ref[REF_W-1:0]);
                n_res.offset_out = '0;
                n_res.status     = onrt_pkg::ST_OK;
            end
            onrt_pkg::RES_RD: begin
                n_res = '{result_ref: '0, offset_out: w_rd_out, status: onrt_pkg::ST_OK};
            end
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctrl.push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (i_ctrl.push) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_insert_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_ctrl.wr_insert) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance entry count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("scan read beyond stored entries");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> w_out_free)
        else $error("result pushed over an item still waiting");
`endif

endmodule
`default_nettype wire

/* hdl/onrt_ctrl.sv */
// Controller of the ordered node reference table: sequences each command.
`timescale 1ns / 1ps
`default_nettype none
module onrt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire onrt_pkg::t_stat i_stat,
    output onrt_pkg::t_ctrl      o_ctrl
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_READ   = 6'b001000,
        S_RDATA  = 6'b010000,
        S_PUSH   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decide commands and next state
    always_comb begin
        n_state        = r_state;
        o_ctrl.capture   = 1'b0;
        o_ctrl.wr_insert = 1'b0;
        o_ctrl.wr_mark   = 1'b0;
        o_ctrl.addr_op   = onrt_pkg::ADDR_HOLD;
        o_ctrl.scan      = 1'b0;
        o_ctrl.res_sel   = onrt_pkg::RES_HOLD;
        o_ctrl.push      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    onrt_pkg::CMD_FIND: begin
                        if (i_stat.empty) begin
                            o_ctrl.res_sel = onrt_pkg::RES_OK;
                            n_state        = S_PUSH;
                        end else begin
                            o_ctrl.addr_op = onrt_pkg::ADDR_ZERO;
                            n_state        = S_SCAN;
                        end
                    end
                    onrt_pkg::CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_ctrl.res_sel = onrt_pkg::RES_FULL;
                        end else begin
                            o_ctrl.wr_insert = 1'b1;
                            o_ctrl.res_sel   = onrt_pkg::RES_INS;
                        end
                        n_state = S_PUSH;
                    end
                    onrt_pkg::CMD_READ: begin
                        if (i_stat.mag_zero) begin
                            o_ctrl.res_sel = onrt_pkg::RES_OK;
                            n_state        = S_PUSH;
                        end else if (i_stat.mag_bad) begin
                            o_ctrl.res_sel = onrt_pkg::RES_BAD;
                            n_state        = S_PUSH;
                        end else begin
                            o_ctrl.addr_op = onrt_pkg::ADDR_MAG;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        if (i_stat.mag_zero || i_stat.mag_bad) begin
                            o_ctrl.res_sel = onrt_pkg::RES_BAD;
                        end else begin
                            o_ctrl.wr_mark = 1'b1;
                            o_ctrl.res_sel = onrt_pkg::RES_OK;
                        end
                        n_state = S_PUSH;
                    end
                endcase
            end
            S_SCAN: begin
                // Walk entries one a cycle, stop at first match or last entry
                o_ctrl.scan = 1'b1;
                priority if (i_stat.hit) begin
                    o_ctrl.res_sel = onrt_pkg::RES_HIT;
                    n_state        = S_PUSH;
                end else if (i_stat.last) begin
                    o_ctrl.res_sel = onrt_pkg::RES_OK;
                    n_state        = S_PUSH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_READ: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                o_ctrl.res_sel = onrt_pkg::RES_RD;
                n_state        = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_ctrl.push = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state == S_DECODE && o_ctrl.addr_op == onrt_pkg::ADDR_ZERO)
        |=> (r_state == S_SCAN))
        else $error("find did not start a scan");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.wr_insert && o_ctrl.wr_mark))
        else $error("insert and mark in the same cycle");
`endif

endmodule
`default_nettype wire

/* hdl/ordered_node_reference_table.sv */
// Top level of the ordered node reference table.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (t_in)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (t_out)
//
//  One item is in work at a time; a finished result waits in the output register
//  while the next item is accepted.
//  Insert and mark pass from decode to push; a valid read also passes through read
//  and read-data; find walks the stored entries in a scan, limited by the offset
//  memory's single read port, which the scan walks one entry per cycle.
//  Reset empties the table at once; no clearing pass runs over the memories.
//  A stalled output holds the result and delays the next result's push.
`timescale 1ns / 1ps
`default_nettype none
module ordered_node_reference_table #(
    parameter int DEPTH       = onrt_pkg::DEPTH,
    parameter int OFFSET_BITS = onrt_pkg::OFFSET_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire onrt_pkg::t_in  i_in_item,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output onrt_pkg::t_out      o_out_item
);

    onrt_pkg::t_ctrl w_ctrl;
    onrt_pkg::t_stat w_stat;

    // Sequence commands
    onrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    // Store entries and build results
    onrt_datapath #(
        .DEPTH       (DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat)
    );

endmodule
`default_nettype wire
